/* sv/pdff_pkg.sv */
// Shared constants, codes and types of the primed direct-form filter.
`default_nettype none

package pdff_pkg;

    localparam int MAX_TAPS        = 64;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 24;
    localparam int COEF_FRAC       = COEF_BITS - 4;
    localparam int COEF_INDEX_BITS = 6;

    localparam int TAP_IDX_BITS    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int HIST_BITS       = 2 * SAMPLE_BITS;
    localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS        = PROD_BITS + $clog2(2 * MAX_TAPS) + 1;

    localparam int TAPS_CFG_BITS   = 7;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 8;
    localparam logic [TAPS_CFG_BITS-1:0] TAPS_RESET = TAPS_CFG_BITS'(64);

    localparam int SAMPLE_LSB      = 0;
    localparam int CIDX_LSB        = SAMPLE_LSB + SAMPLE_BITS;
    localparam int CVAL_LSB        = CIDX_LSB + COEF_INDEX_BITS;
    localparam int IN_FIELD_BITS   = CVAL_LSB + COEF_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_BITS   = 3;
    localparam int OUT_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS  = 1;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_WRITE_A = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TAPS     = CFG_INDEX_BITS'(0),
        REG_FEEDBACK = CFG_INDEX_BITS'(1)
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

/* sv/pdff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pdff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/pdff_mac.sv */
// Shared multiplier, accumulator and round-and-saturate stage.
`default_nettype none

module pdff_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pdff_pkg::mac_ctrl_t                   ctrl,
    input  wire logic signed [pdff_pkg::SAMPLE_BITS-1:0] mul_a,
    input  wire logic signed [pdff_pkg::COEF_BITS-1:0]   mul_b,
    output logic signed      [pdff_pkg::SAMPLE_BITS-1:0] result,
    output logic                                       saturated
);

    localparam int SHIFT_BITS = pdff_pkg::ACC_BITS - pdff_pkg::COEF_FRAC;

    logic signed [pdff_pkg::PROD_BITS-1:0] prod_reg;
    logic                                  prod_valid_reg;
    logic signed [pdff_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [pdff_pkg::ACC_BITS-1:0]  rnd;
    logic signed [SHIFT_BITS-1:0]          shifted;
    logic [SHIFT_BITS-pdff_pkg::SAMPLE_BITS:0] top_bits;
    logic                                  in_range;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + pdff_pkg::ACC_BITS'(prod_reg);
            end
        end
    end

    always_comb
    begin
        rnd       = acc_reg + (pdff_pkg::ACC_BITS'(1) << (pdff_pkg::COEF_FRAC - 1));
        shifted   = rnd[pdff_pkg::ACC_BITS-1:pdff_pkg::COEF_FRAC];
        top_bits  = shifted[SHIFT_BITS-1:pdff_pkg::SAMPLE_BITS-1];
        in_range  = (&top_bits) || !(|top_bits);
        saturated = !in_range;
        if (in_range)
        begin
            result = shifted[pdff_pkg::SAMPLE_BITS-1:0];
        end
        else if (shifted[SHIFT_BITS-1])
        begin
            result = {1'b1, {(pdff_pkg::SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(pdff_pkg::SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

/* sv/primed_direct_form_filter_core.sv */
// Top level of the primed direct-form I filter with one shared multiply-accumulate.
// Each sample walks the taps in use from the last down to tap 0 through the shared unit:
// read, multiply x by b and, with feedback on, multiply y by a (not at tap 0).
// A start-of-record sample first sweeps all MAX_TAPS history entries to fill them with it.
// Result appears in the output register at the end of the item; one item at a time.
// Reset clears state and valid bits, sets TAPS_RESET; unwritten entries read as zero.
`default_nettype none

module primed_direct_form_filter_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample, coef_index, coef_value (zero pad at top)
    input  wire logic [pdff_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // op, start_of_record
    input  wire logic [pdff_pkg::IN_TUSER_BITS-1:0]     s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // result
    output logic      [pdff_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // saturated
    output logic      [pdff_pkg::OUT_TUSER_BITS-1:0]    m_axis_tuser,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [pdff_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [pdff_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int TB = pdff_pkg::TAP_IDX_BITS;
    localparam int SB = pdff_pkg::SAMPLE_BITS;
    localparam int CB = pdff_pkg::COEF_BITS;

    pdff_pkg::state_t state_reg, state_next;
    logic [TB-1:0]    m_reg, m_next;
    logic [TB-1:0]    last_reg, last_next;
    logic signed [SB-1:0] x_reg, x_next;

    logic [pdff_pkg::TAPS_CFG_BITS-1:0] taps_reg;
    logic                               fb_reg;

    logic [pdff_pkg::MAX_TAPS-1:0] hist_valid_reg;
    logic [pdff_pkg::MAX_TAPS-1:0] b_valid_reg;
    logic [pdff_pkg::MAX_TAPS-1:0] a_valid_reg;
    logic                          hist_vq_reg;
    logic                          b_vq_reg;
    logic                          a_vq_reg;

    logic                          out_valid_reg;
    logic signed [SB-1:0]          out_result_reg;
    logic                          out_sat_reg;
    logic                          out_load;

    pdff_pkg::op_t                 in_op;
    logic                          in_start;
    logic signed [SB-1:0]          in_sample;
    logic [pdff_pkg::COEF_INDEX_BITS-1:0] in_cidx;
    logic signed [CB-1:0]          in_cval;
    logic                          in_acc;
    logic                          cidx_ok;
    logic [TB-1:0]                 clamp_last;

    logic                          hist_we;
    logic [TB-1:0]                 hist_waddr;
    logic [pdff_pkg::HIST_BITS-1:0] hist_wdata;
    logic [TB-1:0]                 hist_raddr;
    logic [pdff_pkg::HIST_BITS-1:0] hist_rdata;
    logic                          b_we;
    logic                          a_we;
    logic [CB-1:0]                 b_rdata;
    logic [CB-1:0]                 a_rdata;

    logic signed [SB-1:0]          hist_x;
    logic signed [SB-1:0]          hist_y;
    logic signed [CB-1:0]          b_eff;
    logic signed [CB-1:0]          a_eff;

    pdff_pkg::mac_ctrl_t           mac_ctrl;
    logic signed [SB-1:0]          mul_a;
    logic signed [CB-1:0]          mul_b;
    logic signed [SB-1:0]          mac_result;
    logic                          mac_sat;

    assign in_op     = pdff_pkg::op_t'(s_axis_tuser[1:0]);
    assign in_start  = s_axis_tuser[2];
    assign in_sample = s_axis_tdata[pdff_pkg::SAMPLE_LSB +: SB];
    assign in_cidx   = s_axis_tdata[pdff_pkg::CIDX_LSB +: pdff_pkg::COEF_INDEX_BITS];
    assign in_cval   = s_axis_tdata[pdff_pkg::CVAL_LSB +: CB];

    assign s_axis_tready = (state_reg == pdff_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cidx_ok       = 32'(in_cidx) < 32'(pdff_pkg::MAX_TAPS);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pdff_pkg::OUT_TDATA_BITS'($unsigned(out_result_reg));
    assign m_axis_tuser  = out_sat_reg;

    assign hist_raddr = m_reg - TB'(1);
    assign hist_x = hist_vq_reg ? signed'(hist_rdata[SB-1:0]) : '0;
    assign hist_y = hist_vq_reg ? signed'(hist_rdata[2*SB-1:SB]) : '0;
    assign b_eff  = b_vq_reg ? signed'(b_rdata) : '0;
    assign a_eff  = a_vq_reg ? signed'(a_rdata) : '0;

    always_comb
    begin
        if (taps_reg == '0)
        begin
            clamp_last = '0;
        end
        else if (32'(taps_reg) > 32'(pdff_pkg::MAX_TAPS))
        begin
            clamp_last = TB'(pdff_pkg::MAX_TAPS - 1);
        end
        else
        begin
            clamp_last = TB'(taps_reg - pdff_pkg::TAPS_CFG_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdff_pkg::ST_IDLE;
            m_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        m_next          = m_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        hist_we         = 1'b0;
        hist_waddr      = m_reg;
        hist_wdata      = {hist_y, hist_x};
        b_we            = 1'b0;
        a_we            = 1'b0;
        mac_ctrl.clear  = 1'b0;
        mac_ctrl.mul_en = 1'b0;
        mul_a           = hist_x;
        mul_b           = b_eff;
        out_load        = 1'b0;

        unique case (state_reg)
            pdff_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_op)
                        pdff_pkg::OP_SAMPLE:
                        begin
                            x_next         = in_sample;
                            last_next      = clamp_last;
                            mac_ctrl.clear = 1'b1;
                            if (in_start)
                            begin
                                m_next     = '0;
                                state_next = pdff_pkg::ST_FILL;
                            end
                            else
                            begin
                                m_next     = clamp_last;
                                state_next = pdff_pkg::ST_READ;
                            end
                        end
                        pdff_pkg::OP_WRITE_B:
                        begin
                            b_we = cidx_ok;
                        end
                        pdff_pkg::OP_WRITE_A:
                        begin
                            a_we = cidx_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pdff_pkg::ST_FILL:
            begin
                hist_we    = 1'b1;
                hist_wdata = {x_reg, x_reg};
                if (m_reg == TB'(pdff_pkg::MAX_TAPS - 1))
                begin
                    m_next     = last_reg;
                    state_next = pdff_pkg::ST_READ;
                end
                else
                begin
                    m_next = m_reg + TB'(1);
                end
            end
            pdff_pkg::ST_READ:
            begin
                state_next = pdff_pkg::ST_MUL_X;
            end
            pdff_pkg::ST_MUL_X:
            begin
                mac_ctrl.mul_en = 1'b1;
                if (m_reg == '0)
                begin
                    mul_a      = x_reg;
                    state_next = pdff_pkg::ST_DRAIN;
                end
                else
                begin
                    hist_we = 1'b1;
                    if (fb_reg)
                    begin
                        state_next = pdff_pkg::ST_MUL_Y;
                    end
                    else
                    begin
                        m_next     = m_reg - TB'(1);
                        state_next = pdff_pkg::ST_READ;
                    end
                end
            end
            pdff_pkg::ST_MUL_Y:
            begin
                mac_ctrl.mul_en = 1'b1;
                mul_a           = hist_y;
                mul_b           = a_eff;
                m_next          = m_reg - TB'(1);
                state_next      = pdff_pkg::ST_READ;
            end
            pdff_pkg::ST_DRAIN:
            begin
                state_next = pdff_pkg::ST_RESULT;
            end
            pdff_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    hist_we    = 1'b1;
                    hist_waddr = '0;
                    hist_wdata = {mac_result, x_reg};
                    out_load   = 1'b1;
                    state_next = pdff_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdff_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= pdff_pkg::TAPS_RESET;
            fb_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pdff_pkg::cfg_reg_t'(cfg_index))
                pdff_pkg::REG_TAPS:     taps_reg <= cfg_data[pdff_pkg::TAPS_CFG_BITS-1:0];
                pdff_pkg::REG_FEEDBACK: fb_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            b_valid_reg    <= '0;
            a_valid_reg    <= '0;
            hist_vq_reg    <= 1'b0;
            b_vq_reg       <= 1'b0;
            a_vq_reg       <= 1'b0;
        end
        else
        begin
            if (hist_we)
            begin
                hist_valid_reg[hist_waddr] <= 1'b1;
            end
            if (b_we)
            begin
                b_valid_reg[TB'(in_cidx)] <= 1'b1;
            end
            if (a_we)
            begin
                a_valid_reg[TB'(in_cidx)] <= 1'b1;
            end
            hist_vq_reg <= hist_valid_reg[hist_raddr];
            b_vq_reg    <= b_valid_reg[m_reg];
            a_vq_reg    <= a_valid_reg[m_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_result_reg <= mac_result;
            out_sat_reg    <= mac_sat;
        end
    end

    pdff_ram #(
        .WIDTH (pdff_pkg::HIST_BITS),
        .DEPTH (pdff_pkg::MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    pdff_ram #(
        .WIDTH (CB),
        .DEPTH (pdff_pkg::MAX_TAPS)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (TB'(in_cidx)),
        .wdata (in_cval),
        .raddr (m_reg),
        .rdata (b_rdata)
    );

    pdff_ram #(
        .WIDTH (CB),
        .DEPTH (pdff_pkg::MAX_TAPS)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (TB'(in_cidx)),
        .wdata (in_cval),
        .raddr (m_reg),
        .rdata (a_rdata)
    );

    pdff_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .result    (mac_result),
        .saturated (mac_sat)
    );

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_op == pdff_pkg::OP_SAMPLE |=> !s_axis_tready)
        else $error("block ready in the cycle after a sample item");

    a_shift_in_taps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdff_pkg::ST_MUL_X && hist_we |-> m_reg <= last_reg && m_reg != '0)
        else $error("history shift outside the taps in use");

    a_coef_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (b_we || a_we) |-> state_reg == pdff_pkg::ST_IDLE)
        else $error("coefficient write while a sample is in progress");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pdff_pkg::ST_RESULT && m_axis_tvalid && !m_axis_tready
        |=> state_reg == pdff_pkg::ST_RESULT)
        else $error("result stage advanced over a stalled output");

endmodule

`default_nettype wire

/* tb/filter_checker.sv */
// Checker for the filter core: predicts each output item and compares it with the stream.
`default_nettype none

module filter_checker
    import pdff_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    // sample, coef_index, coef_value (zero pad at top)
    input  wire logic [IN_TDATA_BITS-1:0]    s_axis_tdata,
    // op, start_of_record
    input  wire logic [IN_TUSER_BITS-1:0]    s_axis_tuser,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // result
    input  wire logic [OUT_TDATA_BITS-1:0]   m_axis_tdata,
    // saturated
    input  wire logic [OUT_TUSER_BITS-1:0]   m_axis_tuser,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
    output int                               mismatch_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] result;
        logic                   saturated;
    } filter_out_t;

    logic signed [SAMPLE_BITS-1:0] x_hist [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] y_hist [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   b_coef [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   a_coef [MAX_TAPS];
    logic [TAPS_CFG_BITS-1:0]      taps_cfg;
    logic                          feedback_on;
    logic [COEF_INDEX_BITS-1:0]    coef_idx;
    filter_out_t                   expected_out [$];
    filter_out_t                   expected_head;
    int                            errors;

    task automatic filter_sample(input logic signed [SAMPLE_BITS-1:0] x, input logic prime);
        int          n;
        longint      acc;
        longint      limit_hi;
        filter_out_t item_out;
        n = int'(taps_cfg);
        if (n < 1)
            n = 1;
        if (n > MAX_TAPS)
            n = MAX_TAPS;
        if (prime)
            for (int m = 0; m < MAX_TAPS; m++)
            begin
                x_hist[m] = x;
                y_hist[m] = x;
            end
        for (int m = n - 1; m > 0; m--)
        begin
            x_hist[m] = x_hist[m - 1];
            y_hist[m] = y_hist[m - 1];
        end
        x_hist[0] = x;
        acc = 0;
        for (int m = 0; m < n; m++)
        begin
            acc += longint'(x_hist[m]) * longint'(b_coef[m]);
            if (feedback_on && m > 0)
                acc += longint'(y_hist[m]) * longint'(a_coef[m]);
        end
        acc += longint'(1) <<< (COEF_FRAC - 1);
        acc = acc >>> COEF_FRAC;
        limit_hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        item_out.saturated = 1'b1;
        if (acc > limit_hi)
            acc = limit_hi;
        else if (acc < -limit_hi - 1)
            acc = -limit_hi - 1;
        else
            item_out.saturated = 1'b0;
        item_out.result = acc[SAMPLE_BITS-1:0];
        y_hist[0] = acc[SAMPLE_BITS-1:0];
        expected_out.push_back(item_out);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAX_TAPS; m++)
            begin
                x_hist[m] = '0;
                y_hist[m] = '0;
                b_coef[m] = '0;
                a_coef[m] = '0;
            end
            taps_cfg = TAPS_RESET;
            feedback_on = 1'b0;
            expected_out.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TAPS)
                    taps_cfg = cfg_data[TAPS_CFG_BITS-1:0];
                else if (cfg_index == REG_FEEDBACK)
                    feedback_on = cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                coef_idx = s_axis_tdata[CVAL_LSB-1:CIDX_LSB];
                case (op_t'(s_axis_tuser[1:0]))
                    OP_SAMPLE:
                        filter_sample(s_axis_tdata[CIDX_LSB-1:SAMPLE_LSB], s_axis_tuser[2]);
                    OP_WRITE_B:
                        if (int'(coef_idx) < MAX_TAPS)
                            b_coef[coef_idx] = s_axis_tdata[IN_FIELD_BITS-1:CVAL_LSB];
                    OP_WRITE_A:
                        if (int'(coef_idx) < MAX_TAPS)
                            a_coef[coef_idx] = s_axis_tdata[IN_FIELD_BITS-1:CVAL_LSB];
                    default:
                        ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_out.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output item: result %0d saturated %0b",
                                 $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser[0]);
                end
                else
                begin
                    expected_head = expected_out.pop_front();
                    if (m_axis_tdata !== OUT_TDATA_BITS'(expected_head.result) ||
                        m_axis_tuser[0] !== expected_head.saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected result %0d saturated %0b, got %0d %0b",
                                     $signed(expected_head.result), expected_head.saturated,
                                     $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser[0]);
                    end
                end
            end
            mismatch_count <= errors;
            outstanding <= expected_out.size();
        end
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench top for the filter core: directed and random stimulus, idling phases, verdict.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdff_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 2000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 48;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_BITS-1:0]    s_axis_tdata = '0;
    logic [IN_TUSER_BITS-1:0]    s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;
    logic [OUT_TUSER_BITS-1:0]   m_axis_tuser;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;
    int                          mismatch_count;
    int                          outstanding;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          items_sent = 0;
    logic                        hold_toggle = 1'b0;

    primed_direct_form_filter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    filter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : ready_driver
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input op_t op, input logic prime,
                             input logic [SAMPLE_BITS-1:0] smp,
                             input logic [COEF_INDEX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] coef);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'({coef, idx, smp});
        s_axis_tuser  <= {prime, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2:       return '0;
            3, 4, 5: return SAMPLE_BITS'($urandom_range(600)) - SAMPLE_BITS'(300);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] coef_pick(input int style, input int lim);
        case (style)
            0:       return COEF_BITS'($urandom_range(2 * lim) - lim);
            1:       return COEF_BITS'($urandom);
            default: return $urandom_range(1) ? {1'b0, {(COEF_BITS-1){1'b1}}}
                                              : {1'b1, {(COEF_BITS-1){1'b0}}};
        endcase
    endfunction

    initial
    begin : stimulus
        logic [TAPS_CFG_BITS-1:0] taps_table [PHASES];
        logic                     fb_table   [PHASES];
        int                       n_eff;
        int                       style;
        int                       coef_lim;
        int                       rec_len;
        int                       phase_start;
        logic                     first_rec;
        taps_table = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd2,
                       7'd5, 7'd8, 7'd16, 7'd3, 7'd33, 7'd4};
        fb_table   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                       1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_item(OP_SAMPLE, 1'b0, SAMPLE_BITS'(100), 6'($urandom), 24'($urandom));
        send_item(OP_WRITE_B, 1'b0, 16'($urandom), 6'd0, 24'h7FFFFF);
        send_item(OP_WRITE_B, 1'b1, 16'($urandom), 6'd63, 24'h800000);
        send_item(OP_WRITE_A, 1'b0, 16'($urandom), 6'd0, 24'h7FFFFF);
        send_item(OP_WRITE_A, 1'b1, 16'($urandom), 6'd63, 24'h800000);
        send_item(OP_SAMPLE, 1'b1, 16'h7FFF, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h8000, 6'($urandom), 24'($urandom));
        send_item(OP_NONE, 1'b1, 16'($urandom), 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF, 6'($urandom), 24'($urandom));
        send_item(OP_WRITE_B, 1'b0, 16'($urandom), 6'd63, 24'h000000);
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h8000, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h0000, 6'($urandom), 24'($urandom));
        send_item(OP_WRITE_B, 1'b0, 16'($urandom), 6'd0, 24'h080000);
        send_item(OP_SAMPLE, 1'b1, 16'h0000, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h0001, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'hFFFF, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h0003, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'hFFFD, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b1, 16'h8000, 6'($urandom), 24'($urandom));
        send_item(OP_SAMPLE, 1'b0, 16'h7FFF, 6'($urandom), 24'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
            endcase
            write_reg(REG_TAPS, {1'($urandom_range(1)), taps_table[p]});
            write_reg(REG_FEEDBACK, {7'($urandom), fb_table[p]});
            if (p % 3 == 2)
                write_reg(CFG_INDEX_BITS'($urandom_range(15, 2)), 8'($urandom));

            n_eff = (taps_table[p] == 0) ? 1 : (taps_table[p] > MAX_TAPS) ? MAX_TAPS
                                                                           : taps_table[p];
            style = $urandom_range(2);
            coef_lim = (1 << COEF_FRAC) / n_eff;
            for (int i = 0; i < n_eff; i++)
                send_item(OP_WRITE_B, 1'($urandom), 16'($urandom), 6'(i),
                          coef_pick(style, coef_lim));
            if (fb_table[p])
                for (int i = 0; i < n_eff; i++)
                    send_item(OP_WRITE_A, 1'($urandom), 16'($urandom), 6'(i),
                              coef_pick(style, coef_lim / 2));

            if (p == 0)
                hold_toggle <= ~hold_toggle;

            phase_start = items_sent;
            first_rec = 1'b1;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                rec_len = $urandom_range(24, 4);
                for (int k = 0; k < rec_len; k++)
                begin
                    if ($urandom_range(99) < 12)
                        case ($urandom_range(2))
                            0:
                                send_item(OP_NONE, 1'($urandom), 16'($urandom),
                                          6'($urandom), 24'($urandom));
                            1:
                                send_item(op_t'($urandom_range(2, 1)), 1'($urandom),
                                          16'($urandom), 6'($urandom),
                                          coef_pick(0, coef_lim));
                            default:
                                send_item(OP_SAMPLE, 1'b1, pick_sample(), 6'($urandom),
                                          24'($urandom));
                        endcase
                    else
                        send_item(OP_SAMPLE,
                                  (k == 0) && (first_rec ? 1'($urandom) : 1'b1),
                                  pick_sample(), 6'($urandom), 24'($urandom));
                end
                first_rec = 1'b0;
            end
        end

        wait_idle();
        if (mismatch_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/pdff_pkg.sv
sv/pdff_ram.sv
sv/pdff_mac.sv
sv/primed_direct_form_filter_core.sv
tb/filter_checker.sv
tb/tb.sv
